FILE: sv/postfix_stack_evaluator_assert.svh
// Assertion macros for the postfix stack evaluator RTL.
// Expects i_clk and i_rst_n in the scope of every use.
`ifndef POSTFIX_STACK_EVALUATOR_ASSERT_SVH
`define POSTFIX_STACK_EVALUATOR_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define PSE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Check that a condition implies another one on the following edge.
`define PSE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/pse_pkg.sv
// Shared constants, codes and controller/datapath interface types for the
// postfix stack evaluator. No dependencies.
package pse_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int DATA_W      = 32;
    localparam int KIND_W      = 2;
    localparam int DIGIT_W     = 4;
    localparam int OP_W        = 3;
    localparam int STATUS_W    = 3;
    localparam int DIV_CNT_W   = $clog2(DATA_W);

    localparam logic [KIND_W-1:0] KIND_PUSH = 2'd0;
    localparam logic [KIND_W-1:0] KIND_OPER = 2'd1;
    localparam logic [KIND_W-1:0] KIND_END  = 2'd2;

    localparam logic [OP_W-1:0] OP_ADD   = 3'd0;
    localparam logic [OP_W-1:0] OP_SUB   = 3'd1;
    localparam logic [OP_W-1:0] OP_MUL   = 3'd2;
    localparam logic [OP_W-1:0] OP_DIV   = 3'd3;
    localparam logic [OP_W-1:0] OP_POW   = 3'd4;
    localparam logic [OP_W-1:0] OP_OTHER = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DIVZERO = 3'd1;
    localparam logic [STATUS_W-1:0] ST_UNDER   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_OVER    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd4;

    typedef enum logic [2:0] {
        TOP_HOLD,
        TOP_DIGIT,
        TOP_RDATA,
        TOP_ALU,
        TOP_DIV,
        TOP_POW
    } t_top_sel;

    typedef struct packed {
        logic                ram_we;
        logic [ADDR_W-1:0]   waddr;
        logic                wsel_digit;
        logic [ADDR_W-1:0]   raddr;
        t_top_sel            top_sel;
        logic                op2_load;
        logic                div_start;
        logic                div_step;
        logic                pow_start;
        logic                pow_step;
        logic [OP_W-1:0]     operation;
        logic                out_load;
        logic [STATUS_W-1:0] out_status;
    } t_cmd;

    typedef struct packed {
        logic top_zero;
        logic top_neg;
        logic base_zero;
        logic div_last;
        logic pow_done;
    } t_stat;

endpackage

FILE: sv/pse_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/pse_datapath.sv
// Datapath of the postfix stack evaluator: operand stack RAM, top and operand
// registers, adder, multiplier, iterative divider and power unit, output word.
// Depends on pse_pkg and pse_ram.
module pse_datapath
    import pse_pkg::*;
(
    input  logic                i_clk,
    input  logic [DIGIT_W-1:0]  i_digit,
    input  t_cmd                i_cmd,
    output t_stat               o_stat,
    output logic [DATA_W-1:0]   o_value,
    output logic [STATUS_W-1:0] o_status
);

    logic [DATA_W-1:0]    r_top;
    logic [DATA_W-1:0]    r_op2;
    logic [DATA_W-1:0]    r_rem;
    logic [DATA_W-1:0]    r_quo;
    logic [DATA_W-1:0]    r_den;
    logic                 r_neg;
    logic [DIV_CNT_W-1:0] r_dcnt;
    logic [DATA_W-1:0]    r_acc;
    logic [DATA_W-1:0]    r_sq;
    logic [DATA_W-2:0]    r_exp;
    logic [DATA_W-1:0]    r_value;
    logic [STATUS_W-1:0]  r_status;

    logic [DATA_W-1:0]    w_rdata;
    logic [DATA_W-1:0]    w_wdata;
    logic [DATA_W-1:0]    w_prod;
    logic [DATA_W-1:0]    w_acc_prod;
    logic [DATA_W-1:0]    w_sq_prod;
    logic [DATA_W-1:0]    w_pow_neg;
    logic [DATA_W-1:0]    w_alu;
    logic [DATA_W-1:0]    w_quo_signed;
    logic [DATA_W:0]      w_trial;
    logic [DATA_W:0]      w_diff;
    logic                 w_ge;

    function automatic logic [DATA_W-1:0] f_mag(input logic [DATA_W-1:0] v);
        f_mag = v[DATA_W-1] ? (~v + DATA_W'(1)) : v;
    endfunction

    assign w_wdata = i_cmd.wsel_digit ? DATA_W'(i_digit) : r_top;

    pse_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (i_cmd.ram_we),
        .i_waddr (i_cmd.waddr),
        .i_wdata (w_wdata),
        .i_raddr (i_cmd.raddr),
        .o_rdata (w_rdata)
    );

    assign w_prod     = r_op2 * r_top;
    assign w_acc_prod = r_acc * r_sq;
    assign w_sq_prod  = r_sq * r_sq;

    always_comb begin
        if (r_op2 == DATA_W'(1)) begin
            w_pow_neg = DATA_W'(1);
        end else if (r_op2 == '1) begin
            w_pow_neg = r_top[0] ? '1 : DATA_W'(1);
        end else begin
            w_pow_neg = '0;
        end
    end

    always_comb begin
        case (i_cmd.operation)
            OP_ADD:  w_alu = r_op2 + r_top;
            OP_SUB:  w_alu = r_op2 - r_top;
            OP_MUL:  w_alu = w_prod;
            OP_POW:  w_alu = w_pow_neg;
            default: w_alu = '0;
        endcase
    end

    assign w_trial      = {r_rem, r_quo[DATA_W-1]};
    assign w_diff       = w_trial - {1'b0, r_den};
    assign w_ge         = w_trial >= {1'b0, r_den};
    assign w_quo_signed = r_neg ? (~r_quo + DATA_W'(1)) : r_quo;

    always_ff @(posedge i_clk) begin
        if (i_cmd.op2_load) begin
            r_op2 <= w_rdata;
        end

        if (i_cmd.div_start) begin
            r_rem  <= '0;
            r_quo  <= f_mag(r_op2);
            r_den  <= f_mag(r_top);
            r_neg  <= r_op2[DATA_W-1] ^ r_top[DATA_W-1];
            r_dcnt <= '0;
        end else if (i_cmd.div_step) begin
            r_rem  <= w_ge ? w_diff[DATA_W-1:0] : w_trial[DATA_W-1:0];
            r_quo  <= {r_quo[DATA_W-2:0], w_ge};
            r_dcnt <= r_dcnt + DIV_CNT_W'(1);
        end

        if (i_cmd.pow_start) begin
            r_acc <= DATA_W'(1);
            r_sq  <= r_op2;
            r_exp <= r_top[DATA_W-2:0];
        end else if (i_cmd.pow_step) begin
            if (r_exp[0]) begin
                r_acc <= w_acc_prod;
            end
            r_sq  <= w_sq_prod;
            r_exp <= r_exp >> 1;
        end

        case (i_cmd.top_sel)
            TOP_DIGIT: r_top <= DATA_W'(i_digit);
            TOP_RDATA: r_top <= w_rdata;
            TOP_ALU:   r_top <= w_alu;
            TOP_DIV:   r_top <= w_quo_signed;
            TOP_POW:   r_top <= r_acc;
            default:   r_top <= r_top;
        endcase

        if (i_cmd.out_load) begin
            r_value  <= (i_cmd.out_status == ST_OK) ? r_top : '0;
            r_status <= i_cmd.out_status;
        end
    end

    assign o_stat.top_zero  = (r_top == '0);
    assign o_stat.top_neg   = r_top[DATA_W-1];
    assign o_stat.base_zero = (r_op2 == '0);
    assign o_stat.div_last  = (r_dcnt == '1);
    assign o_stat.pow_done  = (r_exp == '0);

    assign o_value  = r_value;
    assign o_status = r_status;

endmodule

FILE: sv/pse_ctrl.sv
// Controller of the postfix stack evaluator: handshakes, stack count, sticky
// error and the operator sequence. Depends on pse_pkg and the assertion macros.
`include "postfix_stack_evaluator_assert.svh"

module pse_ctrl
    import pse_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [KIND_W-1:0]   i_kind,
    input  logic [OP_W-1:0]     i_operation,
    input  logic                i_stall,
    input  t_stat               i_stat,
    output logic                o_stall,
    output logic                o_valid,
    output t_cmd                o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_POP   = 8'b0000_0010,
        S_FETCH = 8'b0000_0100,
        S_EXEC  = 8'b0000_1000,
        S_DIV   = 8'b0001_0000,
        S_POW   = 8'b0010_0000,
        S_FIN   = 8'b0100_0000,
        S_WB    = 8'b1000_0000
    } t_state;

    t_state              r_state,     n_state;
    logic [CNT_W-1:0]    r_cnt,       n_cnt;
    logic [STATUS_W-1:0] r_err,       n_err;
    logic [OP_W-1:0]     r_op,        n_op;
    logic                r_out_valid, n_out_valid;

    logic                w_acc;
    logic                w_end_acc;
    logic [CNT_W-1:0]    w_cnt_m1;
    logic [CNT_W-1:0]    w_cnt_m2;
    logic [CNT_W-1:0]    w_cnt_m3;
    t_cmd                cmd;

    assign o_stall   = (r_state != S_IDLE) || ((i_kind == KIND_END) && r_out_valid && i_stall);
    assign w_acc     = i_valid && !o_stall;
    assign w_end_acc = w_acc && (i_kind == KIND_END);
    assign w_cnt_m1  = r_cnt - CNT_W'(1);
    assign w_cnt_m2  = r_cnt - CNT_W'(2);
    assign w_cnt_m3  = r_cnt - CNT_W'(3);

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_err       = r_err;
        n_op        = r_op;
        n_out_valid = r_out_valid;
        cmd           = '0;
        cmd.top_sel   = TOP_HOLD;
        cmd.operation = r_op;

        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    case (i_kind)
                        KIND_END: begin
                            cmd.out_load = 1'b1;
                            if (r_err != ST_OK) begin
                                cmd.out_status = r_err;
                            end else if (r_cnt == '0) begin
                                cmd.out_status = ST_EMPTY;
                            end else begin
                                cmd.out_status = ST_OK;
                            end
                            n_out_valid = 1'b1;
                            n_cnt       = '0;
                            n_err       = ST_OK;
                        end
                        KIND_PUSH: begin
                            if (r_err == ST_OK) begin
                                if (r_cnt >= CNT_W'(STACK_DEPTH)) begin
                                    n_err = ST_OVER;
                                end else begin
                                    cmd.ram_we     = 1'b1;
                                    cmd.waddr      = r_cnt[ADDR_W-1:0];
                                    cmd.wsel_digit = 1'b1;
                                    cmd.top_sel    = TOP_DIGIT;
                                    n_cnt          = r_cnt + CNT_W'(1);
                                end
                            end
                        end
                        KIND_OPER: begin
                            if (r_err == ST_OK) begin
                                if (r_cnt < CNT_W'(2)) begin
                                    n_err = ST_UNDER;
                                end else if (i_operation inside
                                             {OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_POW}) begin
                                    n_op      = i_operation;
                                    cmd.raddr = w_cnt_m2[ADDR_W-1:0];
                                    n_state   = S_FETCH;
                                end else begin
                                    n_cnt = w_cnt_m2;
                                    if (w_cnt_m2 != '0) begin
                                        cmd.raddr = w_cnt_m3[ADDR_W-1:0];
                                        n_state   = S_POP;
                                    end
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_POP: begin
                cmd.top_sel = TOP_RDATA;
                n_state     = S_IDLE;
            end
            S_FETCH: begin
                cmd.op2_load = 1'b1;
                n_state      = S_EXEC;
            end
            S_EXEC: begin
                case (r_op)
                    OP_DIV: begin
                        if (i_stat.top_zero) begin
                            n_err   = ST_DIVZERO;
                            n_state = S_IDLE;
                        end else begin
                            cmd.div_start = 1'b1;
                            n_state       = S_DIV;
                        end
                    end
                    OP_POW: begin
                        if (i_stat.top_neg) begin
                            if (i_stat.base_zero) begin
                                n_err   = ST_DIVZERO;
                                n_state = S_IDLE;
                            end else begin
                                cmd.top_sel = TOP_ALU;
                                n_state     = S_WB;
                            end
                        end else begin
                            cmd.pow_start = 1'b1;
                            n_state       = S_POW;
                        end
                    end
                    default: begin
                        cmd.top_sel = TOP_ALU;
                        n_state     = S_WB;
                    end
                endcase
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_FIN;
                end
            end
            S_POW: begin
                if (i_stat.pow_done) begin
                    n_state = S_FIN;
                end else begin
                    cmd.pow_step = 1'b1;
                end
            end
            S_FIN: begin
                cmd.top_sel = (r_op == OP_DIV) ? TOP_DIV : TOP_POW;
                n_state     = S_WB;
            end
            S_WB: begin
                cmd.ram_we = 1'b1;
                cmd.waddr  = w_cnt_m2[ADDR_W-1:0];
                n_cnt      = w_cnt_m1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_err       <= ST_OK;
            r_op        <= OP_ADD;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_err       <= n_err;
            r_op        <= n_op;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_valid = r_out_valid;
    assign o_cmd   = cmd;

    `PSE_ASSERT(a_cnt_range, r_cnt <= CNT_W'(STACK_DEPTH), "stack count beyond depth")
    `PSE_ASSERT_NEXT(a_end_clears, w_end_acc, (r_cnt == '0) && (r_err == ST_OK) && r_out_valid, "end word did not clear stack")
    `PSE_ASSERT_NEXT(a_err_sticky, (r_err != ST_OK) && !w_end_acc, $stable(r_err), "error changed before end")
    `PSE_ASSERT(a_we_state, cmd.ram_we |-> (r_state == S_IDLE) || (r_state == S_WB), "stack write outside idle or write back")

endmodule

FILE: sv/postfix_stack_evaluator.sv
// Postfix stack evaluator: push and end words are handled in the idle state;
// div runs the divider loop, one quotient bit per cycle, and power with a
// non-negative exponent the square-and-multiply loop, one exponent bit per
// cycle; discard reads the new top from the stack RAM. One word in flight at
// a time; an end word's result is valid in the next cycle. Synchronous reset
// (active low) clears stack count, error and output valid; not the stack RAM.
module postfix_stack_evaluator
    import pse_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [KIND_W-1:0]   i_kind,
    input  logic [DIGIT_W-1:0]  i_digit,
    input  logic [OP_W-1:0]     i_operation,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [DATA_W-1:0]   o_value,
    output logic [STATUS_W-1:0] o_status
);

    t_cmd  w_cmd;
    t_stat w_stat;

    pse_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_kind      (i_kind),
        .i_operation (i_operation),
        .i_stall     (i_stall),
        .i_stat      (w_stat),
        .o_stall     (o_stall),
        .o_valid     (o_valid),
        .o_cmd       (w_cmd)
    );

    pse_datapath u_datapath (
        .i_clk    (i_clk),
        .i_digit  (i_digit),
        .i_cmd    (w_cmd),
        .o_stat   (w_stat),
        .o_value  (o_value),
        .o_status (o_status)
    );

endmodule

FILE: verif/tb.sv
`timescale 1ns / 100ps
// Testbench for postfix_stack_evaluator: drives digit, operator and end words and
// checks every reported value and status against a built-in stack evaluator.
// Depends on pse_pkg and the evaluator RTL only.
module tb;
    import pse_pkg::*;

    localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;
    localparam logic [OP_W-1:0] OP_SPARE6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE7 = 3'd7;
    localparam int ITEMS_PER_PHASE = 490;
    localparam int SETTLE_CYCLES = 48;

    typedef struct {
        logic [DATA_W-1:0]   value;
        logic [STATUS_W-1:0] status;
    } t_rpn_result;

    class rpn_checker;
        logic [DATA_W-1:0]   words [STACK_DEPTH];
        int unsigned         fill;
        logic [STATUS_W-1:0] err;
        t_rpn_result         expected [$];
        int                  fails;

        function new();
            fill = 0;
            err = ST_OK;
            fails = 0;
        endfunction

        function bit divide(logic [DATA_W-1:0] num, logic [DATA_W-1:0] den,
                            output logic [DATA_W-1:0] quo);
            logic [DATA_W-1:0] nm, dm;
            if (den == '0) return 1'b0;
            nm = num[DATA_W-1] ? -num : num;
            dm = den[DATA_W-1] ? -den : den;
            quo = nm / dm;
            if (num[DATA_W-1] ^ den[DATA_W-1]) quo = -quo;
            return 1'b1;
        endfunction

        function bit raise(logic [DATA_W-1:0] base, logic [DATA_W-1:0] expo,
                           output logic [DATA_W-1:0] res);
            logic [DATA_W-1:0] acc, sq, e;
            if (expo[DATA_W-1]) begin
                if (base == '0) return 1'b0;
                if (base == 1) res = 1;
                else if (base == '1) res = expo[0] ? '1 : 1;
                else res = '0;
                return 1'b1;
            end
            acc = 1;
            sq = base;
            e = expo;
            while (e != '0) begin
                if (e[0]) acc = acc * sq;
                sq = sq * sq;
                e = e >> 1;
            end
            res = acc;
            return 1'b1;
        endfunction

        function void note_word(logic [KIND_W-1:0] kind, logic [DIGIT_W-1:0] digit,
                                logic [OP_W-1:0] op);
            t_rpn_result       res;
            logic [DATA_W-1:0] a, b, r;
            bit                ok;
            if (kind == KIND_END) begin
                res.value = '0;
                res.status = err;
                if (err == ST_OK) begin
                    if (fill == 0) res.status = ST_EMPTY;
                    else res.value = words[fill-1];
                end
                expected.push_back(res);
                fill = 0;
                err = ST_OK;
                return;
            end
            if (kind == KIND_NONE || err != ST_OK) return;
            if (kind == KIND_PUSH) begin
                if (fill >= STACK_DEPTH) begin
                    err = ST_OVER;
                end else begin
                    words[fill] = DATA_W'(digit);
                    fill++;
                end
                return;
            end
            if (fill < 2) begin
                err = ST_UNDER;
                return;
            end
            a = words[fill-1];
            b = words[fill-2];
            r = '0;
            ok = 1'b1;
            case (op)
                OP_ADD: r = b + a;
                OP_SUB: r = b - a;
                OP_MUL: r = b * a;
                OP_DIV: ok = divide(b, a, r);
                OP_POW: ok = raise(b, a, r);
                default: ;
            endcase
            if (!ok) begin
                err = ST_DIVZERO;
                return;
            end
            fill -= 2;
            if (op <= OP_POW) begin
                words[fill] = r;
                fill++;
            end
        endfunction

        function void check_result(logic [DATA_W-1:0] value, logic [STATUS_W-1:0] status);
            t_rpn_result want;
            if (expected.size() == 0) begin
                $error("unexpected word: value %0d status %0d", $signed(value), status);
                fails++;
                return;
            end
            want = expected.pop_front();
            if (value !== want.value) begin
                $error("value: expected %0d, got %0d", $signed(want.value), $signed(value));
                fails++;
            end
            if (status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, status);
                fails++;
            end
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    logic [KIND_W-1:0]   i_kind;
    logic [DIGIT_W-1:0]  i_digit;
    logic [OP_W-1:0]     i_operation;
    logic                o_valid;
    logic                i_stall;
    logic [DATA_W-1:0]   o_value;
    logic [STATUS_W-1:0] o_status;

    int         idle_pct = 0;
    int         stall_pct = 0;
    int         sent = 0;
    rpn_checker chk = new();

    postfix_stack_evaluator dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("tb: errors");
        $finish;
    end

    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) chk.check_result(o_value, o_status);
    end

    function automatic logic [DIGIT_W-1:0] rand_digit();
        if ($urandom_range(9) < 2) return DIGIT_W'($urandom_range(15));
        return DIGIT_W'($urandom_range(9));
    endfunction

    function automatic logic [OP_W-1:0] rand_op();
        case ($urandom_range(11))
            0, 1: return OP_ADD;
            2, 3: return OP_SUB;
            4, 5: return OP_MUL;
            6, 7: return OP_DIV;
            8, 9: return OP_POW;
            10: return OP_OTHER;
            default: return $urandom_range(1) ? OP_SPARE6 : OP_SPARE7;
        endcase
    endfunction

    task automatic send_word(logic [KIND_W-1:0] kind, logic [DIGIT_W-1:0] digit,
                             logic [OP_W-1:0] op);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_kind <= kind;
        i_digit <= digit;
        i_operation <= op;
        do @(posedge i_clk); while (o_stall);
        chk.note_word(kind, digit, op);
        sent++;
        @(negedge i_clk);
    endtask

    task automatic run_text(string s);
        byte c;
        for (int k = 0; k < s.len(); k++) begin
            c = s[k];
            case (c)
                " ": ;
                "+": send_word(KIND_OPER, rand_digit(), OP_ADD);
                "-": send_word(KIND_OPER, rand_digit(), OP_SUB);
                "*": send_word(KIND_OPER, rand_digit(), OP_MUL);
                "/": send_word(KIND_OPER, rand_digit(), OP_DIV);
                "^": send_word(KIND_OPER, rand_digit(), OP_POW);
                "o": send_word(KIND_OPER, rand_digit(), OP_OTHER);
                "x": send_word(KIND_OPER, rand_digit(), OP_SPARE6);
                "y": send_word(KIND_OPER, rand_digit(), OP_SPARE7);
                "?": send_word(KIND_NONE, rand_digit(), rand_op());
                "=": send_word(KIND_END, rand_digit(), rand_op());
                "F": send_word(KIND_PUSH, 4'd15, rand_op());
                default: send_word(KIND_PUSH, DIGIT_W'(c - "0"), rand_op());
            endcase
        end
    endtask

    task automatic run_expression(bit fill_up);
        int             shape, depth, pushed, n;
        bit             broken, cut;
        logic [OP_W-1:0] op;
        shape = fill_up ? 0 : $urandom_range(99);
        depth = 0;
        pushed = 0;
        broken = (shape >= 16 && shape < 26);
        cut = broken && $urandom_range(1);
        if (shape < 4) begin
            repeat (STACK_DEPTH + $urandom_range(2))
                send_word(KIND_PUSH, rand_digit(), rand_op());
        end else if (shape < 16) begin
            repeat ($urandom_range(1, 10))
                send_word(KIND_W'($urandom_range(3)), DIGIT_W'($urandom_range(15)),
                          OP_W'($urandom_range(7)));
        end else begin
            n = ($urandom_range(19) == 0) ? $urandom_range(8, STACK_DEPTH) : $urandom_range(1, 6);
            while (pushed < n || (depth > 1 && !cut)) begin
                if (depth >= 2 && (pushed == n || $urandom_range(2) == 0)) begin
                    op = rand_op();
                    send_word(KIND_OPER, rand_digit(), op);
                    depth -= (op <= OP_POW) ? 1 : 2;
                end else if (broken && $urandom_range(3) == 0) begin
                    send_word(KIND_OPER, rand_digit(), rand_op());
                end else begin
                    send_word(KIND_PUSH, rand_digit(), rand_op());
                    depth++;
                    pushed++;
                end
            end
        end
        send_word(KIND_END, rand_digit(), rand_op());
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (chk.expected.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    initial begin
        bit first;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_kind = KIND_PUSH;
        i_digit = '0;
        i_operation = OP_ADD;
        first = 1'b1;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        run_text("=");
        run_text("0 0 ^ F + 4 o 3 y =");
        run_text("2 4 8 * 1 - ^ 0 1 - / =");
        run_text("0 1 - 0 1 - ^ 9 9 x ? =");
        run_text("0 0 1 - ^ 3 =");
        run_text("7 0 / =");

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 67; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 67; end
                default: begin idle_pct = 15; stall_pct = 15; end
            endcase
            while (sent < (ph + 1) * ITEMS_PER_PHASE) begin
                run_expression(first);
                first = 1'b0;
            end
            // hold off until every pending result is back
            drain();
        end

        if (chk.fails == 0 && chk.expected.size() == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end
endmodule
